@@ src/ray_sphere_intersect_defines.svh @@
// Assertion macros shared by the ray-sphere intersection RTL.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset.
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rsi_pkg.sv @@
// Types, widths and register codes for the ray-sphere intersection block.
`default_nettype none

package rsi_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_W   = 32;
  localparam int RAD_W   = 31;
  localparam int EPS_W   = 16;
  localparam int DIST_W  = 31;
  localparam int NORM_W  = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [RAD_W-1:0]          rad_t;
  typedef logic [EPS_W-1:0]          eps_t;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_MIN_DIST = 3'd4
  } reg_idx_t;

  localparam rad_t RADIUS_RST   = 31'd65536;
  localparam eps_t MIN_DIST_RST = 16'd7;

endpackage

`default_nettype wire

@@ src/rsi_ray_if.sv @@
// Ray input channel: valid/ready handshake with origin and direction.
`default_nettype none

interface rsi_ray_if;
  import rsi_pkg::*;

  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  dir_t   dir_x;
  dir_t   dir_y;
  dir_t   dir_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

`default_nettype wire

@@ src/rsi_hit_if.sv @@
// Hit result channel: valid/ready handshake with distance and normal.
`default_nettype none

interface rsi_hit_if;
  import rsi_pkg::*;

  logic  valid;
  logic  ready;
  logic  hit;
  logic  far_root;
  dist_t distance;
  norm_t normal_x;
  norm_t normal_y;
  norm_t normal_z;

  modport source (
    output valid, hit, far_root, distance, normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, hit, far_root, distance, normal_x, normal_y, normal_z,
    output ready
  );
endinterface

`default_nettype wire

@@ src/ray_sphere_intersect.sv @@
// Ray-sphere intersection: pipelined hit test, distance and unit normal.
// Throughput: one ray per cycle unless a result waits with the last stage full;
//   the pipeline advances as one, set by the output register, and keeps
//   accepting while its last stage is empty.
// Reset (rst_n, synchronous): pipeline empty, sphere at origin, radius 1.0,
//   min distance 7 (Q16.16). No clearing pass.
`default_nettype none
`include "ray_sphere_intersect_defines.svh"

module ray_sphere_intersect (
  input  logic                         clk,
  input  logic                         rst_n,
  rsi_ray_if.sink                      in_chan,
  rsi_hit_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsi_pkg::ADDR_W-1:0]   paddr,
  input  logic [rsi_pkg::DATA_W-1:0]   pwdata,
  output logic [rsi_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import rsi_pkg::*;

  // ---------------------------------------------------------------------
  // Datapath widths
  // ---------------------------------------------------------------------
  localparam int OP_W   = COORD_W + 1;        // center - origin
  localparam int PD_W   = OP_W + DIR_W;       // op * dir
  localparam int PQ_W   = 2 * OP_W;           // op * op
  localparam int SUM_W  = PD_W + 2;           // dot product
  localparam int B_W    = SUM_W - 30;         // b, Q16.16
  localparam int BLO_W  = 19;                 // low slice of |b|
  localparam int BHI_W  = B_W - BLO_W;
  localparam int R2_W   = 2 * RAD_W;
  localparam int OPSQ_W = PQ_W + 2;
  localparam int DETX_W = 76;                 // signed det, with headroom
  localparam int R1_W   = 37;                 // bits of sqrt(det)
  localparam int DET_W  = 2 * R1_W;
  localparam int T_W    = R1_W + 1;           // root candidate
  localparam int TLO_W  = 19;
  localparam int THI_W  = T_W - TLO_W;
  localparam int PH_W   = DIR_W + THI_W;
  localparam int PL_W   = DIR_W + TLO_W + 1;
  localparam int PR_W   = 72;
  localparam int H_W    = PR_W - 30;          // hit point - center
  localparam int HM_W   = H_W - 1;
  localparam int HLO_W  = 21;
  localparam int HHI_W  = HM_W - HLO_W;
  localparam int R2S_W  = 42;                 // bits of sqrt(h.h)
  localparam int SQ2_W  = 2 * R2S_W;
  localparam int NUM_W  = HM_W + 31;
  localparam int Q_W    = 31;                 // normal quotient bits
  localparam int NSTG   = 13 + R1_W + R2S_W + Q_W;

  // ---------------------------------------------------------------------
  // Configuration registers (APB, always ready)
  // ---------------------------------------------------------------------
  coord_t   center_x_r, center_y_r, center_z_r;
  rad_t     radius_r;
  eps_t     min_dist_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= RADIUS_RST;
      min_dist_r <= MIN_DIST_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CENTER_X: center_x_r <= pwdata;
        REG_CENTER_Y: center_y_r <= pwdata;
        REG_CENTER_Z: center_z_r <= pwdata;
        REG_RADIUS:   radius_r   <= pwdata[RAD_W-1:0];
        REG_MIN_DIST: min_dist_r <= pwdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = center_x_r;
      REG_CENTER_Y: prdata = center_y_r;
      REG_CENTER_Z: prdata = center_z_r;
      REG_RADIUS:   prdata = DATA_W'(radius_r);
      REG_MIN_DIST: prdata = DATA_W'(min_dist_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: all stages move together when en is high. The
  // pipe may still advance while a result waits, as long as the last
  // stage holds no item (bubbles are squeezed out).
  // ---------------------------------------------------------------------
  logic            en;
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;

  assign en             = !out_valid_r || out_chan.ready || !vld_r[NSTG-1];
  assign in_chan.ready  = en;
  assign out_chan.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[NSTG-2:0], in_chan.valid};
      end
      if (en && vld_r[NSTG-1]) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage payload types
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic                       miss;
    logic [B_W-1:0]             b;
    logic [2:0][OP_W-1:0]       op;
    logic [2:0][DIR_W-1:0]      dir;
    logic [DET_W-1:0]           rem;
    logic [R1_W-1:0]            root;
  } sq1_t;

  typedef struct packed {
    logic                       hit;
    logic                       far;
    logic [DIST_W-1:0]          tdist;
    logic [2:0]                 hneg;
    logic [2:0][HM_W-1:0]       hmag;
    logic [SQ2_W-1:0]           rem;
    logic [R2S_W-1:0]           root;
  } sq2_t;

  typedef struct packed {
    logic                       hit;
    logic                       far;
    logic [DIST_W-1:0]          tdist;
    logic [2:0]                 hneg;
    logic                       lenz;
    logic [R2S_W-1:0]           den;
    logic [2:0][NUM_W-1:0]      rem;
    logic [2:0][Q_W-1:0]        q;
  } dv_t;

  // ---------------------------------------------------------------------
  // Stage signals
  // ---------------------------------------------------------------------
  coord_t                   ctr [3];
  coord_t                   org [3];
  dir_t                     din [3];

  logic signed [OP_W-1:0]   s1_op_r  [3];
  dir_t                     s1_dir_r [3];

  logic signed [PD_W-1:0]   s2_p_r   [3];
  logic signed [PQ_W-1:0]   s2_q_r   [3];
  logic [R2_W-1:0]          s2_r2_r;
  logic signed [OP_W-1:0]   s2_op_r  [3];
  dir_t                     s2_dir_r [3];

  logic signed [SUM_W-1:0]  s3_sum;
  logic [OPSQ_W-1:0]        s3_opsq_nxt;
  logic signed [B_W-1:0]    s3_b_r;
  logic [OPSQ_W-1:0]        s3_opsq_r;
  logic [R2_W-1:0]          s3_r2_r;
  logic signed [OP_W-1:0]   s3_op_r  [3];
  dir_t                     s3_dir_r [3];

  logic [B_W-1:0]           s4_bmag;
  logic [2*BLO_W-1:0]       s4_ll_r;
  logic [BLO_W+BHI_W-1:0]   s4_lh_r;
  logic [2*BHI_W-1:0]       s4_hh_r;
  logic signed [B_W-1:0]    s4_b_r;
  logic [OPSQ_W-1:0]        s4_opsq_r;
  logic [R2_W-1:0]          s4_r2_r;
  logic signed [OP_W-1:0]   s4_op_r  [3];
  dir_t                     s4_dir_r [3];

  logic [DETX_W-1:0]        s5_bb;
  logic [DETX_W-1:0]        s5_det;

  sq1_t                     sq1_r    [R1_W+1];
  sq1_t                     sq1_nxt  [R1_W];
  logic [DET_W-1:0]         trial1   [R1_W];

  logic signed [T_W-1:0]    ch_tn, ch_tf, ch_eps;
  logic                     ch_near_ok, ch_far_ok;
  logic                     ch_hit_r, ch_far_r;
  logic signed [T_W-1:0]    ch_t_r;
  logic signed [OP_W-1:0]   ch_op_r  [3];
  dir_t                     ch_dir_r [3];

  logic signed [PH_W-1:0]   mt_ph_r  [3];
  logic signed [PL_W-1:0]   mt_pl_r  [3];
  logic                     mt_hit_r, mt_far_r;
  logic signed [T_W-1:0]    mt_t_r;
  logic signed [OP_W-1:0]   mt_op_r  [3];

  logic signed [PR_W-1:0]   h_prod   [3];
  logic signed [H_W-1:0]    h_r      [3];
  logic                     h_hit_r, h_far_r;
  logic [DIST_W-1:0]        h_dist_r;

  logic [HM_W-1:0]          mg_mag_r [3];
  logic [2:0]               mg_neg_r;
  logic                     mg_hit_r, mg_far_r;
  logic [DIST_W-1:0]        mg_dist_r;

  logic [2*HLO_W-1:0]       sq_ll_r  [3];
  logic [HLO_W+HHI_W-1:0]   sq_lh_r  [3];
  logic [2*HHI_W-1:0]       sq_hh_r  [3];
  logic [HM_W-1:0]          sq_mag_r [3];
  logic [2:0]               sq_neg_r;
  logic                     sq_hit_r, sq_far_r;
  logic [DIST_W-1:0]        sq_dist_r;

  logic [SQ2_W-1:0]         ls_hsq_r [3];
  logic [HM_W-1:0]          ls_mag_r [3];
  logic [2:0]               ls_neg_r;
  logic                     ls_hit_r, ls_far_r;
  logic [DIST_W-1:0]        ls_dist_r;

  sq2_t                     sq2_r    [R2S_W+1];
  sq2_t                     sq2_nxt  [R2S_W];
  logic [SQ2_W-1:0]         trial2   [R2S_W];

  dv_t                      dv_r     [Q_W+1];
  dv_t                      dv_nxt   [Q_W];
  logic [NUM_W-1:0]         trial3   [Q_W];

  norm_t                    nrm      [3];

  logic                     out_hit_r, out_far_r;
  dist_t                    out_dist_r;
  norm_t                    out_nx_r, out_ny_r, out_nz_r;

  assign ctr[0] = center_x_r;
  assign ctr[1] = center_y_r;
  assign ctr[2] = center_z_r;
  assign org[0] = in_chan.origin_x;
  assign org[1] = in_chan.origin_y;
  assign org[2] = in_chan.origin_z;
  assign din[0] = in_chan.dir_x;
  assign din[1] = in_chan.dir_y;
  assign din[2] = in_chan.dir_z;

  // ---------------------------------------------------------------------
  // Combinational pieces of each stage
  // ---------------------------------------------------------------------
  // b = floor(op.dir / 2^30); op.op summed alongside
  always_comb begin
    s3_sum      = SUM_W'(s2_p_r[0]) + SUM_W'(s2_p_r[1]) + SUM_W'(s2_p_r[2]);
    s3_opsq_nxt = OPSQ_W'(s2_q_r[0]) + OPSQ_W'(s2_q_r[1]) + OPSQ_W'(s2_q_r[2]);
  end

  assign s4_bmag = s3_b_r[B_W-1] ? B_W'(-s3_b_r) : B_W'(s3_b_r);

  // det = b^2 + r^2 - op.op; sign bit flags a miss
  always_comb begin
    s5_bb  = (DETX_W'(s4_hh_r) << (2 * BLO_W)) + (DETX_W'(s4_lh_r) << (BLO_W + 1))
           + DETX_W'(s4_ll_r);
    s5_det = s5_bb + DETX_W'(s4_r2_r) - DETX_W'(s4_opsq_r);
  end

  // sqrt(det), one result bit per stage, MSB first
  always_comb begin
    for (int g = 0; g < R1_W; g++) begin
      sq1_nxt[g] = sq1_r[g];
      trial1[g]  = (DET_W'(sq1_r[g].root) << (R1_W - g))
                 | (DET_W'(1) << (2 * (R1_W - 1 - g)));
      if (sq1_r[g].rem >= trial1[g]) begin
        sq1_nxt[g].rem  = sq1_r[g].rem - trial1[g];
        sq1_nxt[g].root = sq1_r[g].root | (R1_W'(1) << (R1_W - 1 - g));
      end
    end
  end

  // Root select: near root first, far root if the near one is too close
  always_comb begin
    ch_tn      = T_W'($signed(sq1_r[R1_W].b)) - $signed({1'b0, sq1_r[R1_W].root});
    ch_tf      = T_W'($signed(sq1_r[R1_W].b)) + $signed({1'b0, sq1_r[R1_W].root});
    ch_eps     = $signed(T_W'(min_dist_r));
    ch_near_ok = ch_tn > ch_eps;
    ch_far_ok  = ch_tf > ch_eps;
  end

  // Hit point relative to center: floor(dir*t / 2^30) - op
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_prod[i] = (PR_W'(mt_ph_r[i]) <<< TLO_W) + PR_W'(mt_pl_r[i]);
    end
  end

  // sqrt(h.h) for the normal length
  always_comb begin
    for (int g = 0; g < R2S_W; g++) begin
      sq2_nxt[g] = sq2_r[g];
      trial2[g]  = (SQ2_W'(sq2_r[g].root) << (R2S_W - g))
                 | (SQ2_W'(1) << (2 * (R2S_W - 1 - g)));
      if (sq2_r[g].rem >= trial2[g]) begin
        sq2_nxt[g].rem  = sq2_r[g].rem - trial2[g];
        sq2_nxt[g].root = sq2_r[g].root | (R2S_W'(1) << (R2S_W - 1 - g));
      end
    end
  end

  // Restoring divide, three lanes share the divisor; one quotient bit per
  // stage. Quotient never exceeds 2^30 since |h_i| <= len.
  always_comb begin
    for (int g = 0; g < Q_W; g++) begin
      dv_nxt[g] = dv_r[g];
      trial3[g] = NUM_W'(dv_r[g].den) << (Q_W - 1 - g);
      for (int i = 0; i < 3; i++) begin
        if (dv_r[g].rem[i] >= trial3[g]) begin
          dv_nxt[g].rem[i] = dv_r[g].rem[i] - trial3[g];
          dv_nxt[g].q[i]   = dv_r[g].q[i] | (Q_W'(1) << (Q_W - 1 - g));
        end
      end
    end
  end

  // Rounded quotient to signed normal; zero on miss or zero length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_r[Q_W].hit || dv_r[Q_W].lenz) begin
        nrm[i] = '0;
      end else if (dv_r[Q_W].hneg[i]) begin
        nrm[i] = -NORM_W'(dv_r[Q_W].q[i]);
      end else begin
        nrm[i] = NORM_W'(dv_r[Q_W].q[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      // op = center - origin
      for (int i = 0; i < 3; i++) begin
        s1_op_r[i]  <= OP_W'(ctr[i]) - OP_W'(org[i]);
        s1_dir_r[i] <= din[i];
      end

      // products
      for (int i = 0; i < 3; i++) begin
        s2_p_r[i]   <= PD_W'(s1_op_r[i]) * PD_W'(s1_dir_r[i]);
        s2_q_r[i]   <= PQ_W'(s1_op_r[i]) * PQ_W'(s1_op_r[i]);
        s2_op_r[i]  <= s1_op_r[i];
        s2_dir_r[i] <= s1_dir_r[i];
      end
      s2_r2_r <= R2_W'(radius_r) * R2_W'(radius_r);

      // dot products
      s3_b_r    <= s3_sum[SUM_W-1:30];
      s3_opsq_r <= s3_opsq_nxt;
      s3_r2_r   <= s2_r2_r;
      for (int i = 0; i < 3; i++) begin
        s3_op_r[i]  <= s2_op_r[i];
        s3_dir_r[i] <= s2_dir_r[i];
      end

      // b^2 as three partial products
      s4_ll_r   <= (2*BLO_W)'(s4_bmag[BLO_W-1:0]) * (2*BLO_W)'(s4_bmag[BLO_W-1:0]);
      s4_lh_r   <= (BLO_W+BHI_W)'(s4_bmag[B_W-1:BLO_W])
                 * (BLO_W+BHI_W)'(s4_bmag[BLO_W-1:0]);
      s4_hh_r   <= (2*BHI_W)'(s4_bmag[B_W-1:BLO_W]) * (2*BHI_W)'(s4_bmag[B_W-1:BLO_W]);
      s4_b_r    <= s3_b_r;
      s4_opsq_r <= s3_opsq_r;
      s4_r2_r   <= s3_r2_r;
      for (int i = 0; i < 3; i++) begin
        s4_op_r[i]  <= s3_op_r[i];
        s4_dir_r[i] <= s3_dir_r[i];
      end

      // determinant into the first sqrt stage
      sq1_r[0].miss <= s5_det[DETX_W-1];
      sq1_r[0].b    <= s4_b_r;
      for (int i = 0; i < 3; i++) begin
        sq1_r[0].op[i]  <= s4_op_r[i];
        sq1_r[0].dir[i] <= s4_dir_r[i];
      end
      sq1_r[0].rem  <= s5_det[DETX_W-1] ? '0 : s5_det[DET_W-1:0];
      sq1_r[0].root <= '0;
      for (int g = 0; g < R1_W; g++) begin
        sq1_r[g+1] <= sq1_nxt[g];
      end

      // root select
      ch_hit_r <= !sq1_r[R1_W].miss && (ch_near_ok || ch_far_ok);
      ch_far_r <= !ch_near_ok;
      ch_t_r   <= ch_near_ok ? ch_tn : ch_tf;
      for (int i = 0; i < 3; i++) begin
        ch_op_r[i]  <= $signed(sq1_r[R1_W].op[i]);
        ch_dir_r[i] <= $signed(sq1_r[R1_W].dir[i]);
      end

      // dir * t, t split in two slices
      for (int i = 0; i < 3; i++) begin
        mt_ph_r[i] <= PH_W'(ch_dir_r[i]) * PH_W'($signed(ch_t_r[T_W-1:TLO_W]));
        mt_pl_r[i] <= PL_W'(ch_dir_r[i]) * PL_W'({1'b0, ch_t_r[TLO_W-1:0]});
        mt_op_r[i] <= ch_op_r[i];
      end
      mt_hit_r <= ch_hit_r;
      mt_far_r <= ch_far_r;
      mt_t_r   <= ch_t_r;

      // hit point minus center; saturated distance
      for (int i = 0; i < 3; i++) begin
        h_r[i] <= $signed(h_prod[i][PR_W-1:30]) - H_W'(mt_op_r[i]);
      end
      h_hit_r  <= mt_hit_r;
      h_far_r  <= mt_far_r;
      h_dist_r <= (|mt_t_r[T_W-2:DIST_W]) ? '1 : mt_t_r[DIST_W-1:0];

      // magnitudes
      for (int i = 0; i < 3; i++) begin
        mg_mag_r[i] <= h_r[i][H_W-1] ? HM_W'(-h_r[i]) : HM_W'(h_r[i]);
        mg_neg_r[i] <= h_r[i][H_W-1];
      end
      mg_hit_r  <= h_hit_r;
      mg_far_r  <= h_far_r;
      mg_dist_r <= h_dist_r;

      // h^2 partial products
      for (int i = 0; i < 3; i++) begin
        sq_ll_r[i]  <= (2*HLO_W)'(mg_mag_r[i][HLO_W-1:0])
                     * (2*HLO_W)'(mg_mag_r[i][HLO_W-1:0]);
        sq_lh_r[i]  <= (HLO_W+HHI_W)'(mg_mag_r[i][HM_W-1:HLO_W])
                     * (HLO_W+HHI_W)'(mg_mag_r[i][HLO_W-1:0]);
        sq_hh_r[i]  <= (2*HHI_W)'(mg_mag_r[i][HM_W-1:HLO_W])
                     * (2*HHI_W)'(mg_mag_r[i][HM_W-1:HLO_W]);
        sq_mag_r[i] <= mg_mag_r[i];
      end
      sq_neg_r  <= mg_neg_r;
      sq_hit_r  <= mg_hit_r;
      sq_far_r  <= mg_far_r;
      sq_dist_r <= mg_dist_r;

      // per-lane squares
      for (int i = 0; i < 3; i++) begin
        ls_hsq_r[i] <= (SQ2_W'(sq_hh_r[i]) << (2 * HLO_W))
                     + (SQ2_W'(sq_lh_r[i]) << (HLO_W + 1)) + SQ2_W'(sq_ll_r[i]);
        ls_mag_r[i] <= sq_mag_r[i];
      end
      ls_neg_r  <= sq_neg_r;
      ls_hit_r  <= sq_hit_r;
      ls_far_r  <= sq_far_r;
      ls_dist_r <= sq_dist_r;

      // |h|^2 into the second sqrt
      sq2_r[0].hit   <= ls_hit_r;
      sq2_r[0].far   <= ls_far_r;
      sq2_r[0].tdist <= ls_dist_r;
      sq2_r[0].hneg  <= ls_neg_r;
      for (int i = 0; i < 3; i++) begin
        sq2_r[0].hmag[i] <= ls_mag_r[i];
      end
      sq2_r[0].rem  <= ls_hsq_r[0] + ls_hsq_r[1] + ls_hsq_r[2];
      sq2_r[0].root <= '0;
      for (int g = 0; g < R2S_W; g++) begin
        sq2_r[g+1] <= sq2_nxt[g];
      end

      // divider setup: (|h| << 30) + len/2 over len
      dv_r[0].hit   <= sq2_r[R2S_W].hit;
      dv_r[0].far   <= sq2_r[R2S_W].far;
      dv_r[0].tdist <= sq2_r[R2S_W].tdist;
      dv_r[0].hneg  <= sq2_r[R2S_W].hneg;
      dv_r[0].lenz  <= (sq2_r[R2S_W].root == '0);
      dv_r[0].den   <= sq2_r[R2S_W].root;
      for (int i = 0; i < 3; i++) begin
        dv_r[0].rem[i] <= (NUM_W'(sq2_r[R2S_W].hmag[i]) << 30)
                        + NUM_W'(sq2_r[R2S_W].root >> 1);
        dv_r[0].q[i]   <= '0;
      end
      for (int g = 0; g < Q_W; g++) begin
        dv_r[g+1] <= dv_nxt[g];
      end

      // output register
      if (vld_r[NSTG-1]) begin
        out_hit_r  <= dv_r[Q_W].hit;
        out_far_r  <= dv_r[Q_W].hit & dv_r[Q_W].far;
        out_dist_r <= dv_r[Q_W].hit ? dv_r[Q_W].tdist : '0;
        out_nx_r   <= nrm[0];
        out_ny_r   <= nrm[1];
        out_nz_r   <= nrm[2];
      end
    end
  end

  assign out_chan.hit      = out_hit_r;
  assign out_chan.far_root = out_far_r;
  assign out_chan.distance = out_dist_r;
  assign out_chan.normal_x = out_nx_r;
  assign out_chan.normal_y = out_ny_r;
  assign out_chan.normal_z = out_nz_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `RSI_ASSERT_IMP(a_miss_zero, out_valid_r && !out_hit_r,
    !out_far_r && out_dist_r == '0 && out_nx_r == '0 && out_ny_r == '0 &&
    out_nz_r == '0, "miss result carries nonzero fields")
  `RSI_ASSERT_IMP(a_far_needs_hit, out_valid_r && out_far_r, out_hit_r,
    "far root flagged without a hit")
  `RSI_ASSERT_IMP(a_stall_cause, !en,
    out_valid_r && !out_chan.ready && vld_r[NSTG-1],
    "input held off without a blocked result")
  `RSI_ASSERT_NXT(a_accept_enters, in_chan.valid && in_chan.ready, vld_r[0],
    "accepted item did not enter the pipeline")

endmodule

`default_nettype wire

@@ tb/ray_sphere_intersect_tb.sv @@
// Self-checking testbench for the ray-sphere intersection block.
`timescale 1ns / 100ps

module ray_sphere_intersect_tb;
  import rsi_pkg::*;

  localparam int       N_RANDOM   = 880;
  localparam int       DRAIN_WAIT = 130;
  localparam int       CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_UNUSED = 3'd7; // decodes to nothing

  typedef struct {
    coord_t ox, oy, oz;
    dir_t   dx, dy, dz;
  } ray_t;

  typedef struct {
    logic  hit;
    logic  far_root;
    dist_t distance;
    norm_t nx, ny, nz;
  } hit_t;

  // Golden hit calculator plus queue of hits still owed by the block.
  class hit_scoreboard;
    logic signed [31:0] cx, cy, cz;
    rad_t radius;
    eps_t min_dist;
    hit_t owed[$];
    int   errors;

    function new();
      cx = 0; cy = 0; cz = 0;
      radius = RADIUS_RST;
      min_dist = MIN_DIST_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_CENTER_X: cx = val;
        REG_CENTER_Y: cy = val;
        REG_CENTER_Z: cz = val;
        REG_RADIUS:   radius = val[30:0];
        REG_MIN_DIST: min_dist = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [127:0] isqrt(logic [127:0] n);
      logic [127:0] root, cand;
      root = 0;
      for (int i = 63; i >= 0; i--) begin
        cand = root | (128'd1 << i);
        if (cand * cand <= n) root = cand;
      end
      return root;
    endfunction

    // floor(a / 2^30), low 64 bits
    function logic signed [63:0] shr30(logic signed [127:0] a);
      logic signed [127:0] s;
      s = a >>> 30;
      return s[63:0];
    endfunction

    function hit_t trace(ray_t r);
      logic signed [127:0] op[3], dv[3], hv[3], acc, det, b, s, t, num, q;
      logic [127:0] len, mag, sum;
      hit_t res;
      res = '{default: 0};
      op[0] = 128'(cx) - 128'(r.ox);
      op[1] = 128'(cy) - 128'(r.oy);
      op[2] = 128'(cz) - 128'(r.oz);
      dv[0] = 128'(r.dx); dv[1] = 128'(r.dy); dv[2] = 128'(r.dz);
      acc = 0;
      for (int i = 0; i < 3; i++) acc = acc + op[i] * dv[i];
      b = shr30(acc);
      det = b * b + $signed({97'd0, radius}) * $signed({97'd0, radius});
      for (int i = 0; i < 3; i++) det = det - op[i] * op[i];
      if (det < 0) return res;
      s = isqrt(det);
      t = b - s;
      if (t <= $signed({112'd0, min_dist})) begin
        t = b + s;
        if (t <= $signed({112'd0, min_dist})) return res;
        res.far_root = 1;
      end
      res.hit = 1;
      res.distance = (t > 128'sh7FFFFFFF) ? 31'h7FFFFFFF : t[30:0];
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        hv[i] = shr30(dv[i] * t) - op[i];
        mag = hv[i] < 0 ? -hv[i] : hv[i];
        sum = sum + mag * mag;
      end
      len = isqrt(sum);
      if (len == 0) return res;  // degenerate sphere touched exactly
      for (int i = 0; i < 3; i++) begin
        mag = hv[i] < 0 ? -hv[i] : hv[i];
        num = $signed((mag << 30) + (len >> 1));
        q = $signed(num / $signed(len));
        if (hv[i] < 0) q = -q;
        case (i)
          0: res.nx = q[31:0];
          1: res.ny = q[31:0];
          default: res.nz = q[31:0];
        endcase
      end
      return res;
    endfunction

    function void note_ray(ray_t r);
      owed.insert(owed.size(), trace(r));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("[%0t] hit mismatch on %s: expected %h got %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_hit(hit_t got);
      hit_t want;
      if (owed.size() == 0) begin
        $display("[%0t] unexpected hit result", $time);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.hit !== want.hit) report("hit", want.hit, got.hit);
      if (got.far_root !== want.far_root) report("far_root", want.far_root, got.far_root);
      if (got.distance !== want.distance) report("distance", want.distance, got.distance);
      if (got.nx !== want.nx) report("normal_x", want.nx, got.nx);
      if (got.ny !== want.ny) report("normal_y", want.ny, got.ny);
      if (got.nz !== want.nz) report("normal_z", want.nz, got.nz);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [ADDR_W-1:0] cfg_paddr = 0;
  logic [DATA_W-1:0] cfg_pwdata = 0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  rsi_ray_if ray_ch ();
  rsi_hit_if hit_ch ();

  hit_scoreboard sb = new();
  bit  calm = 0;          // no idling on either side
  int  stall_left = 0;
  int  cycles = 0;

  always #5 clk = ~clk;

  ray_sphere_intersect u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (ray_ch),
    .out_chan (hit_ch),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready)
  );

  initial begin
    ray_ch.valid = 0;
    ray_ch.origin_x = 0; ray_ch.origin_y = 0; ray_ch.origin_z = 0;
    ray_ch.dir_x = 0; ray_ch.dir_y = 0; ray_ch.dir_z = 0;
    hit_ch.ready = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: ready drops in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      hit_ch.ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      hit_ch.ready <= 0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      hit_ch.ready <= 0;
    end else begin
      hit_ch.ready <= 1;
    end
  end

  // Monitors: record accepted rays, check accepted hits
  always @(posedge clk) begin
    if (rst_n && ray_ch.valid && ray_ch.ready)
      sb.note_ray('{ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
                    ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z});
    if (rst_n && hit_ch.valid && hit_ch.ready)
      sb.check_hit('{hit_ch.hit, hit_ch.far_root, hit_ch.distance,
                     hit_ch.normal_x, hit_ch.normal_y, hit_ch.normal_z});
  end

  // Two-phase APB write; the scoreboard follows the same register
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= ADDR_W'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // Stop sending, then wait until every owed hit has come back
  task automatic wait_drained();
    ray_ch.valid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] rad, logic [31:0] eps);
    wait_drained();
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_MIN_DIST, eps);
  endtask

  // Called at a rising edge. Hold valid until the item is taken; valid
  // stays high into the next send unless an idle gap follows.
  task automatic send_ray(ray_t r);
    ray_ch.valid <= 1;
    ray_ch.origin_x <= r.ox; ray_ch.origin_y <= r.oy; ray_ch.origin_z <= r.oz;
    ray_ch.dir_x <= r.dx; ray_ch.dir_y <= r.dy; ray_ch.dir_z <= r.dz;
    do @(posedge clk); while (!ray_ch.ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      ray_ch.valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] clamp_fix(real v);
    if (v > 2147483647.0) return 32'h7FFFFFFF;
    if (v < -2147483648.0) return 32'h80000000;
    return $rtoi(v);
  endfunction

  function automatic real rnd(real span);
    return ($urandom_range(0, 2000000) / 1000000.0 - 1.0) * span;
  endfunction

  // Ray from near the sphere toward a point around it: mostly hits,
  // sometimes from inside (far root), sometimes a near miss.
  function automatic ray_t aimed_ray();
    real c[3], o[3], d[3], r, nrm;
    ray_t ray;
    c[0] = $itor(sb.cx); c[1] = $itor(sb.cy); c[2] = $itor(sb.cz);
    r = $itor(sb.radius);
    for (int i = 0; i < 3; i++) begin
      o[i] = c[i] + rnd(4.0 * r + 65536.0);
      d[i] = c[i] + rnd(1.3 * r) - o[i];
    end
    nrm = $sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
    if (nrm == 0.0) nrm = 1.0;
    ray.ox = clamp_fix(o[0]); ray.oy = clamp_fix(o[1]); ray.oz = clamp_fix(o[2]);
    ray.dx = clamp_fix(d[0] / nrm * 1073741824.0);
    ray.dy = clamp_fix(d[1] / nrm * 1073741824.0);
    ray.dz = clamp_fix(d[2] / nrm * 1073741824.0);
    return ray;
  endfunction

  // Raw bits on every field
  function automatic ray_t noise_ray();
    return '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic random_rays(int n);
    for (int k = 0; k < n; k++)
      send_ray(($urandom_range(0, 9) < 8) ? aimed_ray() : noise_ray());
  endtask

  localparam dir_t UNIT = 32'sh40000000;
  localparam coord_t ONE = 32'sh00010000;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Directed rays against the reset sphere (unit sphere at origin)
    send_ray('{-5 * ONE, 0, 0, UNIT, 0, 0});              // near root from -x
    send_ray('{0, 0, 0, 0, -UNIT, 0});                    // from center: far root
    send_ray('{0, 3 * ONE, 0, 0, 0, UNIT});               // clean miss
    send_ray('{0, 0, 5 * ONE, 0, 0, -UNIT});              // -z axis
    send_ray('{0, 0, 0, 0, 0, 0});                        // zero direction
    send_ray('{0, 0, -2 * ONE, 0, 0, -UNIT});             // sphere behind the ray
    send_ray('{ONE, 0, -3 * ONE, 0, 0, UNIT});            // grazes the rim
    send_ray('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -UNIT, -UNIT, -UNIT});
    send_ray('{32'sh80000000, 32'sh80000000, 32'sh80000000, UNIT, UNIT, UNIT});
    send_ray('{32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 0}); // over-long direction
    send_ray('{32'sh7FFFFFFF, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000});
    send_ray('{-1, -1, -1, -1, -1, -1});
    wait_drained();
    write_reg(REG_UNUSED, 32'hFFFFFFFF);  // must not touch the sphere
    load_sphere(0, 0, 0, 32'h0001_0000, 32'h0000_0007);

    // Radius zero touched exactly: zero normal; min distance zero
    load_sphere(3 * ONE, -2 * ONE, ONE, 0, 0);
    send_ray('{-2 * ONE, -2 * ONE, ONE, UNIT, 0, 0});
    send_ray('{3 * ONE, -2 * ONE, ONE, UNIT, 0, 0});     // t = 0 is rejected
    send_ray('{3 * ONE, 7 * ONE, ONE, 0, -UNIT, 0});

    // Extremes: far center, largest radius and min distance
    load_sphere(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h0000FFFF);
    send_ray('{32'sh80000000, 0, 0, UNIT, 0, 0});          // just misses the sphere
    send_ray('{32'sh80000000, 32'sh7FFFFFFF, 0, 0, -UNIT, 0});
    send_ray('{0, 0, 0, UNIT, -UNIT, 0});
    random_rays(60);

    // Random spheres of moderate size
    for (int ph = 0; ph < 4; ph++) begin
      load_sphere(clamp_fix(rnd(200.0 * 65536.0)), clamp_fix(rnd(200.0 * 65536.0)),
                  clamp_fix(rnd(200.0 * 65536.0)), $urandom_range(1 << 14, 40 << 16),
                  $urandom_range(0, 65535));
      if (ph == 3) calm = 1;  // final stretch without idling
      random_rays(N_RANDOM / 4 - 40);
      if (ph == 1) begin
        // sender holds until every owed hit has come back
        wait_drained();
      end
      random_rays(40);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
